FILE: rtl/core/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types and constants of the PWM duty cycle to ppm meter.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int CNT_W   = 15;
    localparam int FS_W    = 14;
    localparam int MARG_W  = 4;
    localparam int DEN_W   = CNT_W + 1;
    localparam int PROD_W  = CNT_W + FS_W;
    localparam int STEP_W  = 4;
    localparam int CFG_W   = 15;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_FULL_SCALE    = 2'd1;
    localparam logic [1:0] CFG_EDGE_MARGIN   = 2'd2;

    localparam logic [CNT_W-1:0]  TIMEOUT_RESET = 15'd2200;
    localparam logic [FS_W-1:0]   FULL_SCALE_RESET = 14'd2000;
    localparam logic [MARG_W-1:0] MARGIN_RESET  = 4'd2;

    typedef struct packed {
        logic             emit;
        logic [1:0]       status;
        logic             need_div;
        logic [CNT_W-1:0] high;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] num;
        logic [DEN_W-1:0] den;
    } pdm_event_t;

endpackage

FILE: rtl/core/pdm_ctrl.sv
// ----------------------------------------------------------------------------
// pdm_ctrl
// Phase sequencer: edge search, period counting, budget and pulse checks.
// ----------------------------------------------------------------------------
module pdm_ctrl
    import pdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              kind,
    input  logic              level,
    input  logic [CNT_W-1:0]  timeout_limit,
    input  logic [MARG_W-1:0] edge_margin,
    output pdm_event_t        ev
);

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_WAIT_HIGH_END = 3'd1,
        PH_WAIT_RISE     = 3'd2,
        PH_COUNT_HIGH    = 3'd3,
        PH_COUNT_LOW     = 3'd4
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] budget_reg, budget_next;
    logic [CNT_W-1:0] high_reg, high_next;
    logic [CNT_W-1:0] low_reg, low_next;

    phase_t           p;
    logic [CNT_W-1:0] budget_dec;
    logic [CNT_W-1:0] m_ext;
    logic [CNT_W-1:0] num_w;
    logic [DEN_W-1:0] den_w;

    always_comb
    begin
        phase_next  = phase_reg;
        budget_next = budget_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        p           = phase_reg;
        budget_dec  = budget_reg - CNT_W'(1);
        m_ext       = CNT_W'(edge_margin);
        num_w       = high_reg - m_ext;
        den_w       = {1'b0, num_w} + {1'b0, low_reg - m_ext};
        ev          = '0;
        if (accept)
        begin
            if (!kind)
            begin
                phase_next  = PH_WAIT_HIGH_END;
                budget_next = timeout_limit;
                high_next   = '0;
                low_next    = '0;
            end
            else if (phase_reg inside {[PH_WAIT_HIGH_END:PH_COUNT_LOW]})
            begin
                if (budget_reg == '0)
                begin
                    phase_next = PH_IDLE;
                    ev.emit    = 1'b1;
                    ev.status  = ST_TIMEOUT;
                end
                else
                begin
                    if (p == PH_WAIT_HIGH_END && !level)
                        p = PH_WAIT_RISE;
                    if (p == PH_WAIT_RISE && level)
                        p = PH_COUNT_HIGH;
                    if (p == PH_COUNT_HIGH && !level)
                        p = PH_COUNT_LOW;
                    if (p == PH_COUNT_LOW && level)
                    begin
                        phase_next = PH_IDLE;
                        if (high_reg < m_ext || low_reg < m_ext || den_w == '0)
                        begin
                            ev.emit   = 1'b1;
                            ev.status = ST_INVALID;
                        end
                        else
                        begin
                            ev.need_div = 1'b1;
                            ev.num      = num_w;
                            ev.den      = den_w;
                        end
                    end
                    else
                    begin
                        if (p == PH_COUNT_HIGH)
                            high_next = high_reg + CNT_W'(1);
                        if (p == PH_COUNT_LOW)
                            low_next = low_reg + CNT_W'(1);
                        budget_next = budget_dec;
                        if (budget_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            ev.emit    = 1'b1;
                            ev.status  = ST_TIMEOUT;
                        end
                        else
                        begin
                            phase_next = p;
                        end
                    end
                end
            end
        end
        ev.high = high_next;
        ev.low  = low_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            budget_reg <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            budget_reg <= budget_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
        end
    end

endmodule

FILE: rtl/core/pdm_muldiv.sv
// ----------------------------------------------------------------------------
// pdm_muldiv
// Bit-serial shift-add multiplier followed by a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module pdm_muldiv
    import pdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [FS_W-1:0]  full_scale,
    input  logic [CNT_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [FS_W-1:0]  quotient
);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2,
        S_DONE = 2'd3
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [FS_W-1:0]   fs_reg;
    logic [CNT_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [FS_W-1:0]   qr_reg;

    logic [PROD_W-1:0] acc_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // The low product bits share one shift register with the quotient bits.
    always_comb
    begin
        acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                   + (fs_reg[FS_W-1] ? PROD_W'(num_reg) : PROD_W'(0));
        trial    = {rem_reg, qr_reg[FS_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            fs_reg    <= '0;
            num_reg   <= '0;
            den_reg   <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            qr_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        fs_reg    <= full_scale;
                        num_reg   <= num;
                        den_reg   <= den;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    acc_reg <= acc_next;
                    fs_reg  <= {fs_reg[FS_W-2:0], 1'b0};
                    if (cnt_reg == STEP_W'(FS_W - 1))
                    begin
                        rem_reg   <= DEN_W'(acc_next[PROD_W-1:FS_W]);
                        qr_reg    <= acc_next[FS_W-1:0];
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + STEP_W'(1);
                    end
                end
                S_DIV:
                begin
                    rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    qr_reg  <= {qr_reg[FS_W-2:0], ge};
                    cnt_reg <= cnt_reg + STEP_W'(1);
                    if (cnt_reg == STEP_W'(FS_W - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign quotient = qr_reg;

endmodule

FILE: rtl/core/pwm_duty_ppm_meter.sv
// ----------------------------------------------------------------------------
// pwm_duty_ppm_meter
// Measures a sensor PWM period from millisecond ticks and reports its ppm.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals
//  s_axis    in         s_tvalid, s_tready, s_tuser (kind), s_tdata (pin_level)
//  m_axis    out        m_tvalid, m_tready, m_tdata (status, ppm, high, low)
//  cfg       in         cfg_we, cfg_addr, cfg_wdata
//
//  A start or a tick is taken when s_tready is high. The tick that closes a
//  valid period stalls the input through 14 multiply steps, 14 divide
//  steps, the done state and the holding register. Any other result
//  stalls the input while it sits in the holding register. Either kind
//  of result waits there longer while the output register is full and
//  not taken.
//  Reset clears the phase, counters and handshake state and loads the
//  register defaults.
// ----------------------------------------------------------------------------
module pwm_duty_ppm_meter
    import pdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] pin_level
    input  logic             s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // [1:0] status, [15:2] ppm,
                                        // [30:16] high_time, [45:31] low_time
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CNT_W-1:0]  timeout_reg;
    logic [FS_W-1:0]   full_scale_reg;
    logic [MARG_W-1:0] margin_reg;

    logic              accept;
    pdm_event_t        ev;
    logic              md_busy;
    logic              md_done;
    logic [FS_W-1:0]   md_quot;

    logic              pend_valid_reg;
    logic [1:0]        pend_status_reg;
    logic [FS_W-1:0]   pend_ppm_reg;
    logic [CNT_W-1:0]  pend_high_reg;
    logic [CNT_W-1:0]  pend_low_reg;
    logic [CNT_W-1:0]  div_high_reg;
    logic [CNT_W-1:0]  div_low_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;
    logic              out_load;

    assign s_tready = !md_busy && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_load = pend_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
            margin_reg     <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TIMEOUT_LIMIT: timeout_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_FULL_SCALE:    full_scale_reg <= cfg_wdata[FS_W-1:0];
                CFG_EDGE_MARGIN:   margin_reg     <= cfg_wdata[MARG_W-1:0];
                default:           timeout_reg    <= timeout_reg;
            endcase
        end
    end

    pdm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .kind          (s_tuser),
        .level         (s_tdata[0]),
        .timeout_limit (timeout_reg),
        .edge_margin   (margin_reg),
        .ev            (ev)
    );

    pdm_muldiv u_muldiv (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ev.need_div),
        .full_scale (full_scale_reg),
        .num        (ev.num),
        .den        (ev.den),
        .busy       (md_busy),
        .done       (md_done),
        .quotient   (md_quot)
    );

    always_ff @(posedge clk)
    begin
        if (ev.need_div)
        begin
            div_high_reg <= ev.high;
            div_low_reg  <= ev.low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_status_reg <= ST_OK;
            pend_ppm_reg    <= '0;
            pend_high_reg   <= '0;
            pend_low_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (ev.emit)
            begin
                pend_valid_reg  <= 1'b1;
                pend_status_reg <= ev.status;
                pend_ppm_reg    <= '0;
                pend_high_reg   <= ev.high;
                pend_low_reg    <= ev.low;
            end
            else if (md_done)
            begin
                pend_valid_reg  <= 1'b1;
                pend_status_reg <= ST_OK;
                pend_ppm_reg    <= md_quot;
                pend_high_reg   <= div_high_reg;
                pend_low_reg    <= div_low_reg;
            end
            else if (out_load)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {2'b00, pend_low_reg, pend_high_reg,
                                  pend_ppm_reg, pend_status_reg};
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: tb/sv/tb_pwm_duty_ppm_meter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pwm_duty_ppm_meter
// Drives start and millisecond tick transfers into the PWM duty meter and
// checks every reading against a cycle-free predictor of the measurement.
// Directed cases cover the basic reading, rearming, degenerate pulses and
// zero or one tick budgets. Random traffic then runs under several register
// settings and with random gaps on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_pwm_duty_ppm_meter;
    import pdm_pkg::*;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   CYCLE_LIMIT   = 400000;

    typedef enum logic [2:0] {
        MEAS_IDLE,
        MEAS_HIGH_END,
        MEAS_RISE,
        MEAS_HIGH,
        MEAS_LOW
    } meas_phase_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [FS_W-1:0]  ppm;
        logic [CNT_W-1:0] high_time;
        logic [CNT_W-1:0] low_time;
    } reading_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'd0;   // [0] pin_level
    logic             s_tuser = 1'b0;   // [0] kind
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [47:0]      m_tdata;          // [1:0] status, [15:2] ppm,
                                        // [30:16] high_time, [45:31] low_time
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_addr = 2'd0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    meas_phase_t      pred_phase = MEAS_IDLE;
    logic [CNT_W-1:0] pred_budget = '0;
    logic [CNT_W-1:0] pred_high = '0;
    logic [CNT_W-1:0] pred_low = '0;
    logic [CNT_W-1:0] cur_timeout = TIMEOUT_RESET;
    logic [FS_W-1:0]  cur_full_scale = FULL_SCALE_RESET;
    logic [MARG_W-1:0] cur_margin = MARGIN_RESET;

    reading_t    expected_readings[$];
    int unsigned items_sent = 0;
    int unsigned readings_ok = 0;
    int unsigned readings_timeout = 0;
    int unsigned readings_invalid = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    pwm_duty_ppm_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d readings outstanding",
                     cycle_count, expected_readings.size());
            $display("pwm_duty_ppm_meter test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_reading(input logic [1:0] status, input logic [FS_W-1:0] ppm);
        reading_t r;
        r.status    = status;
        r.ppm       = ppm;
        r.high_time = pred_high;
        r.low_time  = pred_low;
        expected_readings.push_back(r);
    endtask

    // Uses one unit of the tick budget and times out when it runs dry.
    task automatic burn_budget();
        pred_budget = pred_budget - 1'b1;
        if (pred_budget == '0)
        begin
            pred_phase = MEAS_IDLE;
            push_reading(ST_TIMEOUT, '0);
        end
    endtask

    task automatic predict_reading(input logic kind, input logic level);
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [31:0]      prod;
        logic [31:0]      quot;
        if (kind == KIND_START)
        begin
            pred_phase  = MEAS_HIGH_END;
            pred_budget = cur_timeout;
            pred_high   = '0;
            pred_low    = '0;
            return;
        end
        if (pred_phase == MEAS_IDLE)
            return;
        if (pred_budget == '0)
        begin
            pred_phase = MEAS_IDLE;
            push_reading(ST_TIMEOUT, '0);
            return;
        end
        if (pred_phase == MEAS_HIGH_END)
        begin
            if (level)
            begin
                burn_budget();
                return;
            end
            pred_phase = MEAS_RISE;
        end
        if (pred_phase == MEAS_RISE)
        begin
            if (!level)
            begin
                burn_budget();
                return;
            end
            pred_phase = MEAS_HIGH;
        end
        if (pred_phase == MEAS_HIGH)
        begin
            if (level)
            begin
                pred_high = pred_high + 1'b1;
                burn_budget();
                return;
            end
            pred_phase = MEAS_LOW;
        end
        if (!level)
        begin
            pred_low = pred_low + 1'b1;
            burn_budget();
            return;
        end
        pred_phase = MEAS_IDLE;
        if (pred_high < CNT_W'(cur_margin) || pred_low < CNT_W'(cur_margin))
        begin
            push_reading(ST_INVALID, '0);
            return;
        end
        num = DEN_W'(pred_high - CNT_W'(cur_margin));
        den = num + DEN_W'(pred_low - CNT_W'(cur_margin));
        if (den == '0)
        begin
            push_reading(ST_INVALID, '0);
            return;
        end
        prod = 32'(cur_full_scale) * 32'(num);
        quot = prod / {16'd0, den};
        push_reading(ST_OK, quot[FS_W-1:0]);
    endtask

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tdata[1:0];
            got.ppm       = m_tdata[15:2];
            got.high_time = m_tdata[30:16];
            got.low_time  = m_tdata[45:31];
            case (got.status)
                ST_OK:      readings_ok++;
                ST_TIMEOUT: readings_timeout++;
                default:    readings_invalid++;
            endcase
            if (expected_readings.size() == 0)
                report_mismatch($sformatf("unexpected reading status %0d ppm %0d",
                                          got.status, got.ppm));
            else
            begin
                want = expected_readings.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.ppm !== want.ppm)
                    report_mismatch($sformatf("ppm %0d, expected %0d",
                                              got.ppm, want.ppm));
                if (got.high_time !== want.high_time)
                    report_mismatch($sformatf("high_time %0d, expected %0d",
                                              got.high_time, want.high_time));
                if (got.low_time !== want.low_time)
                    report_mismatch($sformatf("low_time %0d, expected %0d",
                                              got.low_time, want.low_time));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic kind, input logic level);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, level};
        do
            @(posedge clk);
        while (!s_tready);
        predict_reading(kind, level);
        items_sent++;
    endtask

    task automatic send_reading(input int unsigned lead_hi, input int unsigned lead_lo,
                                input int unsigned th, input int unsigned tl);
        send_item(KIND_START, 1'($urandom_range(1)));
        repeat (lead_hi) send_item(KIND_TICK, 1'b1);
        repeat (lead_lo) send_item(KIND_TICK, 1'b0);
        repeat (th) send_item(KIND_TICK, 1'b1);
        repeat (tl) send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
    endtask

    // Waits until every reading has come back and a division has had time to end.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_TIMEOUT_LIMIT: cur_timeout    = value[CNT_W-1:0];
            CFG_FULL_SCALE:    cur_full_scale = value[FS_W-1:0];
            CFG_EDGE_MARGIN:   cur_margin     = value[MARG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] fs,
                                  input logic [CFG_W-1:0] margin);
        settle();
        cfg_we <= 1'b1;
        put_register(CFG_TIMEOUT_LIMIT, limit);
        put_register(CFG_FULL_SCALE, fs);
        put_register(CFG_EDGE_MARGIN, margin);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_random_settings();
        apply_settings(CFG_W'($urandom_range(200, 10)), CFG_W'($urandom_range(10000, 1)),
                       CFG_W'($urandom_range(15)));
    endtask

    task automatic test_idle_tick();
        send_item(KIND_TICK, 1'b1);
    endtask

    task automatic test_basic_reading();
        send_reading(1, 1, 3, 3);
    endtask

    // A start in the middle of a measurement rearms it; the rearmed
    // period then spans exactly twice the margin, which leaves no divisor.
    task automatic test_rearm_zero_span();
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_reading(0, 1, 2, 2);
    endtask

    task automatic test_timeout_limits();
        settle();
        cfg_we <= 1'b1;
        put_register(CFG_TIMEOUT_LIMIT, '0);
        cfg_we <= 1'b0;
        send_item(KIND_START, 1'b1);
        send_item(KIND_TICK, 1'b1);
        settle();
        cfg_we <= 1'b1;
        put_register(CFG_TIMEOUT_LIMIT, 15'd1);
        cfg_we <= 1'b0;
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b0);
    endtask

    task automatic send_random_reading();
        int unsigned lo_len;
        int unsigned hi_len;
        hi_len = cur_margin + 6;
        lo_len = (cur_margin > 2) ? cur_margin - 2 : 1;
        send_reading($urandom_range(3), $urandom_range(3),
                     $urandom_range(hi_len, lo_len), $urandom_range(hi_len, lo_len));
    endtask

    task automatic run_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                               input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_random_reading();
            else if (pick < 88)
            begin
                send_item(KIND_START, 1'($urandom_range(1)));
                repeat ($urandom_range(6, 1))
                    send_item(KIND_TICK, 1'($urandom_range(1)));
            end
            else
                repeat ($urandom_range(6, 1))
                    send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_traffic();
        apply_settings(15'd32767, 15'd10000, 15'd0);
        run_traffic(0, 0, 78);
        apply_random_settings();
        run_traffic(0, 0, 78);
        apply_settings(15'd20, 15'd1, 15'd15);
        run_traffic(76, 0, 78);
        apply_random_settings();
        run_traffic(76, 0, 78);
        apply_settings(15'd32767, 15'd10000, 15'd15);
        run_traffic(0, 76, 78);
        apply_random_settings();
        run_traffic(0, 76, 78);
        apply_settings(15'd12, 15'd9999, 15'd1);
        run_traffic(37, 37, 78);
        apply_random_settings();
        run_traffic(37, 37, 78);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_tick();
        test_basic_reading();
        test_rearm_zero_span();
        test_timeout_limits();
        test_random_traffic();
        settle();
        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived",
                                      expected_readings.size()));
        $display("Sent %0d transfers in directed cases and eight random phases with four idle patterns.",
                 items_sent);
        $display("Checked %0d ok, %0d timeout and %0d invalid readings; %0d errors.",
                 readings_ok, readings_timeout, readings_invalid, error_count);
        if (error_count == 0)
            $display("pwm_duty_ppm_meter test passed");
        else
            $display("pwm_duty_ppm_meter test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pdm_pkg.sv
rtl/core/pdm_ctrl.sv
rtl/core/pdm_muldiv.sv
rtl/core/pwm_duty_ppm_meter.sv
tb/sv/tb_pwm_duty_ppm_meter.sv
